### rtl/deq_pkg.sv
package deq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REF_NONE,
        REF_FRONT,
        REF_BACK
    } t_refresh;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         entry_count;
        logic [1:0]         status;
    } t_out_word;

endpackage

### rtl/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/double_ended_queue_core.sv
// Bounded double-ended queue held in a ring RAM.
// Input channel (i_valid / o_stall, word i_in_word): one operation per word,
// push back, push front, pop front, pop back or query; other codes query.
// Output channel (o_valid / i_stall, word o_out_word): exactly one word per
// input word, in order, with the front and back values after the operation
// (0 when empty), the entry count and a status (ok, pop on empty, push on full).
// An accepted word is first held as pending; its result is then registered in the
// output register. No new word is taken (o_stall high) while a result is pending,
// so the registered RAM read can fetch the new front or back entry after a pop.
// Front and back values are cached in registers; the RAM is written on pushes
// and its read data is used only after pops.
// When the receiver stalls, the result stays in the output register and
// o_stall rises until the result is taken; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the deque and drops any pending
// result; the RAM content is not cleared and needs no clearing pass.
module double_ended_queue_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  deq_pkg::t_in_word  i_in_word,
    output logic               o_valid,
    input  logic               i_stall,
    output deq_pkg::t_out_word o_out_word
);

    import deq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S  = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    function automatic logic [IW-1:0] wrap_idx(input logic [CW:0] s);
        logic [CW:0] t;
        t = (s >= DEPTH_S) ? s - DEPTH_S : s;
        return t[IW-1:0];
    endfunction

    logic [IW-1:0]         r_head,     n_head;
    logic [CW-1:0]         r_count,    n_count;
    logic [DATA_WIDTH-1:0] r_front,    n_front;
    logic [DATA_WIDTH-1:0] r_back,     n_back;
    logic                  r_pend,     n_pend;
    t_refresh              r_refresh,  n_refresh;
    t_status               r_status,   n_status;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out,      n_out;

    logic                         acc;
    logic                         out_free;
    logic                         we;
    logic [IW-1:0]                waddr;
    logic [IW-1:0]                raddr;
    logic [DATA_WIDTH-1:0]        rd_data;
    logic signed [31:0]           push_val;
    logic signed [63:0]           push_ext;
    logic [DATA_WIDTH-1:0]        push_data;
    logic signed [DATA_WIDTH-1:0] front_eff;
    logic signed [DATA_WIDTH-1:0] back_eff;
    logic signed [63:0]           front_ext;
    logic signed [63:0]           back_ext;

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (push_data),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_pend || !out_free;
    assign acc      = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_out_word = r_out;

    assign push_val  = i_in_word.push_value;
    assign push_ext  = 64'(push_val);
    assign push_data = push_ext[DATA_WIDTH-1:0];

    assign front_eff = (r_refresh == REF_FRONT) ? rd_data : r_front;
    assign back_eff  = (r_refresh == REF_BACK)  ? rd_data : r_back;
    assign front_ext = 64'(front_eff);
    assign back_ext  = 64'(back_eff);

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_pend      = r_pend;
        n_refresh   = r_refresh;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_head;
        raddr       = r_head;
        if (acc) begin
            n_pend    = 1'b1;
            n_refresh = REF_NONE;
            n_status  = ST_OK;
            unique case (t_op'(i_in_word.operation))
                OP_PUSH_BACK: begin
                    if (r_count == DEPTH_C) begin
                        n_status = ST_FULL;
                    end else begin
                        we     = 1'b1;
                        waddr  = wrap_idx((CW + 1)'(r_head) + {1'b0, r_count});
                        n_back = push_data;
                        if (r_count == '0) begin
                            n_front = push_data;
                        end
                        n_count = r_count + 1'b1;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (r_count == DEPTH_C) begin
                        n_status = ST_FULL;
                    end else begin
                        n_head  = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
                        we      = 1'b1;
                        waddr   = n_head;
                        n_front = push_data;
                        if (r_count == '0) begin
                            n_back = push_data;
                        end
                        n_count = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_head  = wrap_idx((CW + 1)'(r_head) + (CW + 1)'(1));
                        n_count = r_count - 1'b1;
                        raddr   = n_head;
                        if (r_count != CW'(1)) begin
                            n_refresh = REF_FRONT;
                        end
                    end
                end
                OP_POP_BACK: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                        raddr   = wrap_idx((CW + 1)'(r_head) + {1'b0, r_count}
                                           - (CW + 1)'(2));
                        if (r_count != CW'(1)) begin
                            n_refresh = REF_BACK;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (r_pend) begin
            n_pend      = 1'b0;
            n_front     = front_eff;
            n_back      = back_eff;
            n_out_valid = 1'b1;
            n_out.front_value = (r_count == '0) ? 32'sd0 : front_ext[31:0];
            n_out.back_value  = (r_count == '0) ? 32'sd0 : back_ext[31:0];
            n_out.entry_count = 5'(r_count);
            n_out.status      = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front   <= n_front;
        r_back    <= n_back;
        r_refresh <= n_refresh;
        r_status  <= n_status;
        r_out     <= n_out;
    end

endmodule
